### sv/tdis_pkg.sv
// Shared types, codes and a helper function for the two-door interlock sequencer.
package tdis_pkg;

    localparam int ID_BITS_DEF     = 16;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int CMD_W           = 4;
    localparam int CODE_W          = 5;
    localparam int VALUE_W         = 16;

    typedef enum logic [CMD_W-1:0] {
        EV_LS  = 4'd0,
        EV_RS  = 4'd1,
        EV_WS  = 4'd2,
        EV_LO  = 4'd3,
        EV_RO  = 4'd4,
        EV_LC  = 4'd5,
        EV_RC  = 4'd6,
        EV_GLU = 4'd7,
        EV_GLL = 4'd8,
        EV_GRU = 4'd9,
        EV_GRL = 4'd10
    } t_cmd;

    typedef enum logic [CODE_W-1:0] {
        ST_IDLE            = 5'd0,
        ST_L_SCAN          = 5'd1,
        ST_L_UNLOCK_ENTRY  = 5'd2,
        ST_L_OPEN_ENTRY    = 5'd3,
        ST_L_WEIGH         = 5'd4,
        ST_L_CLOSED_ENTRY  = 5'd5,
        ST_L_LOCKED_ENTRY  = 5'd6,
        ST_R_UNLOCK_ENTRY  = 5'd7,
        ST_R_OPEN_ENTRY    = 5'd8,
        ST_R_CLOSED_ENTRY  = 5'd9,
        ST_R_LOCKED_ENTRY  = 5'd10,
        ST_R_SCAN          = 5'd11,
        ST_R_UNLOCK_EXIT   = 5'd12,
        ST_R_OPEN_EXIT     = 5'd13,
        ST_R_WEIGH         = 5'd14,
        ST_R_CLOSED_EXIT   = 5'd15,
        ST_R_LOCKED_EXIT   = 5'd16,
        ST_L_UNLOCK_EXIT   = 5'd17,
        ST_L_OPEN_EXIT     = 5'd18,
        ST_L_CLOSED_EXIT   = 5'd19,
        ST_L_LOCKED_EXIT   = 5'd20,
        ST_ALERT           = 5'd21
    } t_state;

    typedef struct packed {
        logic en;
        t_cmd ev;
    } t_await;

    // What one processed event produces: a first result and maybe the return to idle.
    typedef struct packed {
        logic               has;
        logic               two;
        t_state             code;
        logic [VALUE_W-1:0] value;
    } t_step_res;

    typedef struct packed {
        t_state             code;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_result;

    // Event that each chained waiting state advances on.
    function automatic t_await f_awaited(input t_state st);
        t_await a;
        a.en = 1'b1;
        a.ev = EV_LS;
        unique case (st)
            ST_L_SCAN:         a.ev = EV_GLU;
            ST_L_UNLOCK_ENTRY: a.ev = EV_LO;
            ST_L_OPEN_ENTRY:   a.ev = EV_WS;
            ST_L_WEIGH:        a.ev = EV_LC;
            ST_L_CLOSED_ENTRY: a.ev = EV_GLL;
            ST_L_LOCKED_ENTRY: a.ev = EV_GRU;
            ST_R_UNLOCK_ENTRY: a.ev = EV_RO;
            ST_R_OPEN_ENTRY:   a.ev = EV_RC;
            ST_R_CLOSED_ENTRY: a.ev = EV_GRL;
            ST_R_SCAN:         a.ev = EV_GRU;
            ST_R_UNLOCK_EXIT:  a.ev = EV_RO;
            ST_R_OPEN_EXIT:    a.ev = EV_WS;
            ST_R_WEIGH:        a.ev = EV_RC;
            ST_R_CLOSED_EXIT:  a.ev = EV_GRL;
            ST_R_LOCKED_EXIT:  a.ev = EV_GLU;
            ST_L_UNLOCK_EXIT:  a.ev = EV_LO;
            ST_L_OPEN_EXIT:    a.ev = EV_LC;
            ST_L_CLOSED_EXIT:  a.ev = EV_GLL;
            default:           a.en = 1'b0;
        endcase
        return a;
    endfunction

endpackage

### sv/tdis_if.sv
// Valid/ready channel interfaces for events in and state reports out.
interface tdis_evt_if
    import tdis_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [15:0]        card_id;
    logic [15:0]        weight;

    modport source (output valid, output cmd, output card_id, output weight, input ready);
    modport sink   (input valid, input cmd, input card_id, input weight, output ready);
endinterface

interface tdis_res_if
    import tdis_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CODE_W-1:0]  state_code;
    logic [VALUE_W-1:0] shown_value;
    logic               last;

    modport source (output valid, output state_code, output shown_value, output last,
                    input ready);
    modport sink   (input valid, input state_code, input shown_value, input last,
                    output ready);
endinterface

### sv/tdis_core.sv
// Door sequencing state machine with the kept entry and exit IDs and weights.
module tdis_core
    import tdis_pkg::*;
#(
    parameter int ID_BITS     = ID_BITS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [CMD_W-1:0] i_cmd,
    input  logic [15:0]      i_card_id,
    input  logic [15:0]      i_weight,
    output t_step_res        o_step
);

    // Only the low bits that reach the block can ever be kept.
    localparam int ID_KEEP = (ID_BITS < 16) ? ID_BITS : 16;
    localparam int WT_KEEP = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;

    t_state               r_state, n_state;
    logic [ID_KEEP-1:0]   r_entry_id, n_entry_id;
    logic [ID_KEEP-1:0]   r_exit_id, n_exit_id;
    logic [WT_KEEP-1:0]   r_entry_wt, n_entry_wt;
    logic [WT_KEEP-1:0]   r_exit_wt, n_exit_wt;

    logic [ID_KEEP-1:0]   w_id_in;
    logic [WT_KEEP-1:0]   w_wt_in;
    t_await               w_await;
    t_state               w_chain;
    logic                 w_match;
    logic                 w_alert;

    assign w_id_in = i_card_id[ID_KEEP-1:0];
    assign w_wt_in = i_weight[WT_KEEP-1:0];
    assign w_await = f_awaited(r_state);
    assign w_chain = t_state'(CODE_W'(r_state) + CODE_W'(1));
    assign w_alert = (r_state == ST_R_LOCKED_EXIT) && (r_entry_wt != r_exit_wt)
                     && (r_entry_id == r_exit_id);

    always_comb begin
        if (r_state == ST_IDLE) begin
            w_match = (i_cmd == CMD_W'(EV_LS)) || (i_cmd == CMD_W'(EV_RS));
        end else begin
            w_match = w_await.en && (i_cmd == CMD_W'(w_await.ev));
        end
    end

    // Next state and kept values.
    always_comb begin
        n_state    = r_state;
        n_entry_id = r_entry_id;
        n_exit_id  = r_exit_id;
        n_entry_wt = r_entry_wt;
        n_exit_wt  = r_exit_wt;
        if (w_match) begin
            if (r_state == ST_IDLE) begin
                if (i_cmd == CMD_W'(EV_LS)) begin
                    n_state    = ST_L_SCAN;
                    n_entry_id = w_id_in;
                end else begin
                    n_state   = ST_R_SCAN;
                    n_exit_id = w_id_in;
                end
            end else if (w_alert) begin
                n_state = ST_IDLE;
            end else begin
                n_state = w_chain;
                if (w_chain == ST_L_WEIGH) begin
                    n_entry_wt = w_wt_in;
                end
                if (w_chain == ST_R_WEIGH) begin
                    n_exit_wt = w_wt_in;
                end
                if (w_chain == ST_R_LOCKED_ENTRY || w_chain == ST_L_LOCKED_EXIT) begin
                    n_state = ST_IDLE;
                end
            end
        end
    end

    // Reported result for the event at hand.
    always_comb begin
        o_step.has   = w_match;
        o_step.value = '0;
        if (r_state == ST_IDLE) begin
            o_step.code = (i_cmd == CMD_W'(EV_LS)) ? ST_L_SCAN : ST_R_SCAN;
        end else if (w_alert) begin
            o_step.code = ST_ALERT;
        end else begin
            o_step.code = w_chain;
        end
        unique case (o_step.code)
            ST_L_SCAN, ST_R_SCAN:   o_step.value = VALUE_W'(w_id_in);
            ST_L_WEIGH, ST_R_WEIGH: o_step.value = VALUE_W'(w_wt_in);
            ST_ALERT:               o_step.value = VALUE_W'(r_exit_id);
            default:                o_step.value = '0;
        endcase
        o_step.two = (o_step.code == ST_R_LOCKED_ENTRY) || (o_step.code == ST_L_LOCKED_EXIT)
                     || (o_step.code == ST_ALERT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_entry_id <= '0;
            r_exit_id  <= '0;
            r_entry_wt <= '0;
            r_exit_wt  <= '0;
        end else if (i_fire) begin
            r_state    <= n_state;
            r_entry_id <= n_entry_id;
            r_exit_id  <= n_exit_id;
            r_entry_wt <= n_entry_wt;
            r_exit_wt  <= n_exit_wt;
        end
    end

endmodule

### sv/two_door_interlock_sequencer_top.sv
// Top level of the two-door interlock sequencer: input register, sequencer and result register.
//
// The block takes one door, scale or guard event per transfer and reports each state
// it enters. An event passes through an input register and the sequencer into the
// result register, so its first result is offered from the result register once
// the sequencer processes the event, which waits while that register is busy.
// One event can be accepted in every cycle; the limit is the single result register,
// which lets an event that produces a result proceed only when that register is free
// or being taken and no second result waits behind it. Events that end a walk (entry
// locked, exit locked or alert) give two results and hold the result register for two
// output transfers. Events that match nothing give no result and are dropped without waiting.
module two_door_interlock_sequencer_top
    import tdis_pkg::*;
#(
    parameter int ID_BITS     = ID_BITS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tdis_evt_if.sink   i_evt,
    tdis_res_if.source o_res
);

    logic             r_in_valid;
    logic [CMD_W-1:0] r_in_cmd;
    logic [15:0]      r_in_cid;
    logic [15:0]      r_in_wt;

    logic             r_out_valid;
    t_result          r_out;
    logic             r_pend;

    t_step_res        w_step;
    logic             w_can_load;
    logic             w_proc;

    // The result register can take a new first result once nothing is queued behind it and it is empty or being taken.
    assign w_can_load = !r_pend && (!r_out_valid || o_res.ready);
    assign w_proc     = r_in_valid && (w_can_load || !w_step.has);
    assign i_evt.ready = !r_in_valid || w_proc;

    tdis_core #(
        .ID_BITS     (ID_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_proc),
        .i_cmd       (r_in_cmd),
        .i_card_id   (r_in_cid),
        .i_weight    (r_in_wt),
        .o_step      (w_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_in_cmd <= i_evt.cmd;
            r_in_cid <= i_evt.card_id;
            r_in_wt  <= i_evt.weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            priority if (r_pend && o_res.ready) begin
                r_pend <= 1'b0;
            end else if (w_proc && w_step.has) begin
                r_out_valid <= 1'b1;
                r_pend      <= w_step.two;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (r_pend && o_res.ready) begin
            r_out.code  <= ST_IDLE;
            r_out.value <= '0;
            r_out.last  <= 1'b1;
        end else if (w_proc && w_step.has) begin
            r_out.code  <= w_step.code;
            r_out.value <= w_step.value;
            r_out.last  <= !w_step.two;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.state_code  = r_out.code;
    assign o_res.shown_value = r_out.value;
    assign o_res.last        = r_out.last;

endmodule
